// ===== hdl/aig_binary_and_gate_decoder_defines.svh =====
// Assertion macros for the binary AND-section decoder.
`ifndef AIG_BINARY_AND_GATE_DECODER_DEFINES_SVH
`define AIG_BINARY_AND_GATE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AIG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aig decoder assertion failed");
// next-cycle implication
`define AIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aig decoder assertion failed");
`else
`define AIG_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define AIG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/aig_dec_pkg.sv =====
// Types and constants of the binary AND-section decoder.
package aig_dec_pkg;

    localparam int OUT_W       = 32;
    localparam int CFG_W       = 30;
    localparam int CFG_IDX_W   = 2;
    localparam int POS_W       = 3;
    localparam int VAR_PAY_W   = 7;
    localparam int VAR_MORE    = 7;
    localparam logic [POS_W-1:0] VAR_MAX_POS = 3'd4;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_NEG      = 2'd1,
        ERR_ZERO_D0  = 2'd2,
        ERR_OVERLONG = 2'd3
    } t_err_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_INPUTS = 2'd0,
        REG_NUM_ANDS   = 2'd1
    } t_cfg_idx;

endpackage

// ===== hdl/aig_dec_ifs.sv =====
// Stream and configuration channel interfaces of the decoder.
interface aig_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;

    modport source(output valid, data_byte, first, input ready);
    modport sink(input valid, data_byte, first, output ready);
endinterface

interface aig_out_if;
    logic                          valid;
    logic                          ready;
    logic [aig_dec_pkg::OUT_W-1:0] gate_label;
    logic [aig_dec_pkg::OUT_W-1:0] left_literal;
    logic [aig_dec_pkg::OUT_W-1:0] right_literal;
    logic [1:0]                    error_code;
    logic                          last;

    modport source(output valid, gate_label, left_literal, right_literal, error_code, last,
                   input ready);
    modport sink(input valid, gate_label, left_literal, right_literal, error_code, last,
                 output ready);
endinterface

interface aig_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [aig_dec_pkg::CFG_IDX_W-1:0] index;
    logic [aig_dec_pkg::CFG_W-1:0]     data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/aig_binary_and_gate_decoder.sv =====
// Decoder of the binary AND-gate section: byte stream in, one word per gate out.
// Takes one byte per clock with no gaps of its own while the output is not stalled; a gate
// word appears in the output register in the cycle after the byte that ends the gate's
// second delta, and a waiting output word does not block input while the consumer takes it
// in the same cycle. The per-byte path is a varint shift-or, the label add and two literal
// subtracts with their compares, all in one pass before the output register. An error word
// (negative fanin, zero first delta, number longer than five bytes) is sticky and
// marked last; a byte with first set restarts decoding. Bytes after the last gate
// give nothing. Literals are computed modulo 2^LITERAL_BITS.
`include "aig_binary_and_gate_decoder_defines.svh"

module aig_binary_and_gate_decoder #(
    parameter int LITERAL_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aig_in_if.sink          i_in,
    aig_cfg_if.sink         i_cfg,
    aig_out_if.source       o_out
);
    import aig_dec_pkg::*;

    localparam int CW = (LITERAL_BITS > OUT_W) ? LITERAL_BITS : OUT_W;
    localparam logic [CW-1:0] LIT_MASK = {CW{1'b1}} >> (CW - LITERAL_BITS);

    // configuration
    logic [CFG_W-1:0] r_num_inputs;
    logic [CFG_W-1:0] r_num_ands;

    // decode state
    logic [OUT_W-1:0] r_acc,   n_acc;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic             r_phase, n_phase;
    logic [OUT_W-1:0] r_held,  n_held;
    logic [CFG_W-1:0] r_gc,    n_gc;
    logic             r_stopped, n_stopped;

    // output register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_label, r_out_left, r_out_right;
    t_err_code        r_out_err;
    logic             r_out_last;

    logic             w_in_acc;
    logic             w_emit;
    logic [OUT_W-1:0] w_res_left, w_res_right;
    t_err_code        w_res_err;
    logic             w_res_last;

    // state after an optional restart
    logic [OUT_W-1:0] w_acc;
    logic [POS_W-1:0] w_pos;
    logic             w_phase;
    logic [CFG_W-1:0] w_gc;
    logic             w_stopped;
    logic             w_active;

    logic [6:0]       w_pay;
    logic [OUT_W-1:0] w_shifted;
    logic [OUT_W-1:0] w_acc_or;
    logic [CFG_W:0]   w_label_half;
    logic [CW-1:0]    w_label;
    logic [CW-1:0]    w_d0, w_d1;
    logic [CW-1:0]    w_left, w_right;
    logic             w_neg;
    logic [CFG_W-1:0] w_gc_inc;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;

    assign w_acc     = i_in.first ? '0 : r_acc;
    assign w_pos     = i_in.first ? '0 : r_pos;
    assign w_phase   = i_in.first ? 1'b0 : r_phase;
    assign w_gc      = i_in.first ? '0 : r_gc;
    assign w_stopped = i_in.first ? 1'b0 : r_stopped;
    assign w_active  = !w_stopped && (w_gc < r_num_ands);

    assign w_pay = i_in.data_byte[VAR_PAY_W-1:0];

    // place the 7-bit group; bits above 31 on the fifth byte are dropped
    always_comb begin
        unique case (w_pos)
            3'd0:    w_shifted = {25'd0, w_pay};
            3'd1:    w_shifted = {18'd0, w_pay, 7'd0};
            3'd2:    w_shifted = {11'd0, w_pay, 14'd0};
            3'd3:    w_shifted = {4'd0, w_pay, 21'd0};
            3'd4:    w_shifted = {w_pay[3:0], 28'd0};
            default: w_shifted = '0;
        endcase
    end

    assign w_acc_or = w_acc | w_shifted;

    // label = 2*(inputs+count+1); fits 32 bits for 30-bit operands
    assign w_label_half = {1'b0, r_num_inputs} + {1'b0, w_gc} + (CFG_W+1)'(1);
    assign w_label      = CW'({w_label_half, 1'b0}) & LIT_MASK;
    assign w_d0         = CW'(r_held);
    assign w_d1         = CW'(w_acc_or);
    assign w_left       = (w_label - w_d0) & LIT_MASK;
    assign w_right      = (w_left - w_d1) & LIT_MASK;
    assign w_neg        = (w_d0 > w_label) || (w_d1 > w_left);
    assign w_gc_inc     = w_gc + CFG_W'(1);

    always_comb begin
        n_acc       = w_acc;
        n_pos       = w_pos;
        n_phase     = w_phase;
        n_held      = i_in.first ? '0 : r_held;
        n_gc        = w_gc;
        n_stopped   = w_stopped;
        w_emit      = 1'b0;
        w_res_left  = w_left[OUT_W-1:0];
        w_res_right = w_right[OUT_W-1:0];
        w_res_err   = ERR_NONE;
        w_res_last  = 1'b0;
        if (w_active) begin
            n_acc = w_acc_or;
            if (i_in.data_byte[VAR_MORE]) begin
                if (w_pos >= VAR_MAX_POS) begin
                    n_stopped   = 1'b1;
                    w_emit      = 1'b1;
                    w_res_left  = '0;
                    w_res_right = '0;
                    w_res_err   = ERR_OVERLONG;
                    w_res_last  = 1'b1;
                end else begin
                    n_pos = w_pos + POS_W'(1);
                end
            end else begin
                n_acc = '0;
                n_pos = '0;
                if (!w_phase) begin
                    n_held  = w_acc_or;
                    n_phase = 1'b1;
                end else begin
                    n_phase = 1'b0;
                    w_emit  = 1'b1;
                    priority if (w_neg) begin
                        n_stopped  = 1'b1;
                        w_res_err  = ERR_NEG;
                        w_res_last = 1'b1;
                    end else if (r_held == '0) begin
                        n_stopped  = 1'b1;
                        w_res_err  = ERR_ZERO_D0;
                        w_res_last = 1'b1;
                    end else begin
                        n_gc       = w_gc_inc;
                        w_res_last = (w_gc_inc == r_num_ands);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_inputs <= '0;
            r_num_ands   <= '0;
            r_acc        <= '0;
            r_pos        <= '0;
            r_phase      <= 1'b0;
            r_held       <= '0;
            r_gc         <= '0;
            r_stopped    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_NUM_INPUTS) begin
                    r_num_inputs <= i_cfg.data;
                end else if (i_cfg.index == REG_NUM_ANDS) begin
                    r_num_ands <= i_cfg.data;
                end
            end
            if (w_in_acc) begin
                r_acc     <= n_acc;
                r_pos     <= n_pos;
                r_phase   <= n_phase;
                r_held    <= n_held;
                r_gc      <= n_gc;
                r_stopped <= n_stopped;
            end
            if (w_in_acc && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_emit) begin
            r_out_label <= w_label[OUT_W-1:0];
            r_out_left  <= w_res_left;
            r_out_right <= w_res_right;
            r_out_err   <= w_res_err;
            r_out_last  <= w_res_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.gate_label    = r_out_label;
    assign o_out.left_literal  = r_out_left;
    assign o_out.right_literal = r_out_right;
    assign o_out.error_code    = r_out_err;
    assign o_out.last          = r_out_last;

    `AIG_ASSERT_NOW(a_err_is_last, i_clk, i_rst_n, (r_out_valid && r_out_err != ERR_NONE), r_out_last)
    `AIG_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, 1'b1, (r_pos <= VAR_MAX_POS))
    `AIG_ASSERT_NEXT(a_stop_sticky, i_clk, i_rst_n, (w_in_acc && !i_in.first && r_stopped), r_stopped)
    `AIG_ASSERT_NOW(a_lit_order, i_clk, i_rst_n, (r_out_valid && r_out_err == ERR_NONE), (r_out_right <= r_out_left && r_out_left < r_out_label))

endmodule
